// ----- hdl/bmhq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes, codes and controller/datapath interface types for the
// binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY   = 64;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int AW         = (IDX_W + 2 > 7) ? IDX_W + 2 : 7;

    localparam int KIND_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = 7;

    localparam int IN_DATA_W  = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_W + ENTRY_W + 7) / 8) * 8;
    localparam int IN_PAD     = IN_DATA_W - VALUE_W - POS_W;
    localparam int OUT_PAD    = OUT_DATA_W - VALUE_W - ENTRY_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_EXTRACT = 2'd2,
        KIND_PEEK    = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_ROOT   = 2'd0,
        RD_PARENT = 2'd1,
        RD_CHILD  = 2'd2
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_A    = 2'd1,
        WR_B    = 2'd2,
        WR_KEY  = 2'd3
    } t_wr_sel;

    typedef struct packed {
        logic    load_in;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        logic    start_insert;
        logic    start_remove;
        logic    start_extract;
        logic    hole_up;
        logic    hole_left;
        logic    hole_right;
        logic    dec_fill;
        logic    set_result;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  empty;
        logic  pos_bad;
        logic  pos_last;
        logic  fill_one;
        logic  up_move;
        logic  dn_left;
        logic  dn_right;
    } t_stat;

endpackage
`default_nettype wire

// ----- hdl/bmhq_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap memory, moving key, hole index, fill count, comparators and the
// result output register.
// ----------------------------------------------------------------------------
module bmhq_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bmhq_pkg::t_cmd                 i_cmd,
    output bmhq_pkg::t_stat                     o_stat,
    input  wire logic [bmhq_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [bmhq_pkg::VALUE_W-1:0]   i_value,
    input  wire logic [bmhq_pkg::POS_W-1:0]     i_position,
    output logic      [bmhq_pkg::VALUE_W-1:0]   o_result_value,
    output logic      [bmhq_pkg::STATUS_W-1:0]  o_status,
    output logic      [bmhq_pkg::ENTRY_W-1:0]   o_entry_count
);
    import bmhq_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_rd_a;
    logic signed [VALUE_W-1:0] r_rd_b;
    logic signed [VALUE_W-1:0] r_key;
    logic signed [VALUE_W-1:0] r_in_value;
    logic signed [VALUE_W-1:0] r_res;
    t_kind                     r_kind;
    logic [POS_W-1:0]          r_pos;
    t_status                   r_status;
    logic [IDX_W-1:0]          r_hole;
    logic [CNT_W-1:0]          r_fill;

    logic [VALUE_W-1:0]        r_out_res;
    t_status                   r_out_status;
    logic [ENTRY_W-1:0]        r_out_count;

    logic [AW-1:0]             fill_ext;
    logic [AW-1:0]             lc;
    logic [AW-1:0]             rc;
    logic [IDX_W-1:0]          parent;
    logic [IDX_W-1:0]          last_idx;
    logic [IDX_W-1:0]          addr_a;
    logic [IDX_W-1:0]          addr_b;
    logic                      wr_en;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      dn_left;
    logic signed [VALUE_W-1:0] left_best;

    assign fill_ext = AW'(r_fill);
    assign lc       = AW'({r_hole, 1'b1});
    assign rc       = lc + AW'(1);
    assign parent   = IDX_W'((r_hole - IDX_W'(1)) >> 1);
    assign last_idx = IDX_W'(r_fill - CNT_W'(1));

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_PARENT: begin
                addr_a = parent;
                addr_b = parent;
            end
            RD_CHILD: begin
                addr_a = IDX_W'(lc);
                addr_b = IDX_W'(rc);
            end
            default: begin
                addr_a = '0;
                addr_b = last_idx;
            end
        endcase
    end

    always_comb begin
        wr_en = 1'b1;
        unique case (i_cmd.wr_sel)
            WR_A:    wr_data = r_rd_a;
            WR_B:    wr_data = r_rd_b;
            WR_KEY:  wr_data = r_key;
            default: begin
                wr_en   = 1'b0;
                wr_data = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_hole] <= wr_data;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    assign dn_left   = (lc < fill_ext) && (r_rd_a < r_key);
    assign left_best = dn_left ? r_rd_a : r_key;

    always_comb begin
        o_stat.kind     = r_kind;
        o_stat.full     = (r_fill >= CNT_W'(CAPACITY));
        o_stat.empty    = (r_fill == '0);
        o_stat.pos_bad  = (AW'(r_pos) >= fill_ext);
        o_stat.pos_last = (AW'(r_pos) == fill_ext - AW'(1));
        o_stat.fill_one = (r_fill == CNT_W'(1));
        o_stat.up_move  = (r_hole != '0) && (r_key < r_rd_a);
        o_stat.dn_left  = dn_left;
        o_stat.dn_right = (rc < fill_ext) && (r_rd_b < left_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.start_insert) begin
            r_fill <= r_fill + CNT_W'(1);
        end else if (i_cmd.dec_fill) begin
            r_fill <= r_fill - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind     <= t_kind'(i_kind);
            r_in_value <= i_value;
            r_pos      <= i_position;
            r_res      <= '0;
            r_status   <= ST_OK;
        end
        if (i_cmd.set_result) begin
            r_res <= r_rd_a;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.start_insert) begin
            r_key  <= r_in_value;
            r_hole <= IDX_W'(r_fill);
        end else if (i_cmd.start_remove) begin
            r_key  <= r_rd_b;
            r_hole <= IDX_W'(r_pos);
        end else if (i_cmd.start_extract) begin
            r_key  <= r_rd_b;
            r_hole <= '0;
        end else if (i_cmd.hole_up) begin
            r_hole <= parent;
        end else if (i_cmd.hole_left) begin
            r_hole <= IDX_W'(lc);
        end else if (i_cmd.hole_right) begin
            r_hole <= IDX_W'(rc);
        end
        if (i_cmd.out_load) begin
            r_out_res    <= r_res;
            r_out_status <= r_status;
            r_out_count  <= ENTRY_W'(r_fill);
        end
    end

    assign o_result_value = r_out_res;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;

endmodule
`default_nettype wire

// ----- hdl/bmhq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for the heap operations: decode, fetch, sift up, sift down,
// place the moving key and hand the result to the output register.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire bmhq_pkg::t_stat i_stat,
    output bmhq_pkg::t_cmd       o_cmd
);
    import bmhq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_LOAD   = 9'b000000100,
        S_UP_RD  = 9'b000001000,
        S_UP_CMP = 9'b000010000,
        S_DN_RD  = 9'b000100000,
        S_DN_CMP = 9'b001000000,
        S_PLACE  = 9'b010000000,
        S_FINISH = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_try_down;
    logic   n_try_down;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        n_try_down = r_try_down;
        o_cmd      = '0;
        o_cmd.rd_sel = RD_ROOT;
        o_cmd.wr_sel = WR_NONE;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.kind == KIND_INSERT) begin
                    if (i_stat.full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FULL;
                        n_state          = S_FINISH;
                    end else begin
                        o_cmd.start_insert = 1'b1;
                        n_try_down         = 1'b0;
                        n_state            = S_UP_RD;
                    end
                end else if (i_stat.empty) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_EMPTY;
                    n_state          = S_FINISH;
                end else if (i_stat.kind == KIND_REMOVE && i_stat.pos_bad) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_BAD_POS;
                    n_state          = S_FINISH;
                end else if (i_stat.kind == KIND_REMOVE && i_stat.pos_last) begin
                    o_cmd.dec_fill = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                unique case (i_stat.kind)
                    KIND_PEEK: begin
                        o_cmd.set_result = 1'b1;
                        n_state          = S_FINISH;
                    end
                    KIND_EXTRACT: begin
                        o_cmd.set_result    = 1'b1;
                        o_cmd.dec_fill      = 1'b1;
                        o_cmd.start_extract = 1'b1;
                        n_state = i_stat.fill_one ? S_FINISH : S_DN_RD;
                    end
                    KIND_REMOVE: begin
                        o_cmd.dec_fill     = 1'b1;
                        o_cmd.start_remove = 1'b1;
                        n_try_down         = 1'b1;
                        n_state            = S_UP_RD;
                    end
                    KIND_INSERT: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_UP_RD: begin
                o_cmd.rd_sel = RD_PARENT;
                n_state      = S_UP_CMP;
            end
            S_UP_CMP: begin
                priority if (i_stat.up_move) begin
                    o_cmd.wr_sel  = WR_A;
                    o_cmd.hole_up = 1'b1;
                    n_try_down    = 1'b0;
                    n_state       = S_UP_RD;
                end else if (r_try_down) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_RD: begin
                o_cmd.rd_sel = RD_CHILD;
                n_state      = S_DN_CMP;
            end
            S_DN_CMP: begin
                priority if (i_stat.dn_right) begin
                    o_cmd.wr_sel     = WR_B;
                    o_cmd.hole_right = 1'b1;
                    n_state          = S_DN_RD;
                end else if (i_stat.dn_left) begin
                    o_cmd.wr_sel    = WR_A;
                    o_cmd.hole_left = 1'b1;
                    n_state         = S_DN_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.wr_sel = WR_KEY;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_try_down  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_try_down  <= n_try_down;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/binary_min_heap_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue on an array-backed binary min-heap of signed 32-bit values.
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)                     tuser
//  s_axis   in         value[31:0], position[37:32], pad      kind
//  m_axis   out        result_value[31:0], entry_count[38:32] status
//
//  One item at a time. Each sift level is a registered memory read, then a
//  compare and move through the single write port; accept, decode, fetch,
//  place and hand-off are states of their own. An error goes from decode
//  straight to the hand-off.
//  Synchronous active-low reset empties the heap; the store is not cleared.
//  A result waiting on m_axis holds the next item at its hand-off only.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // value, position
    input  wire logic [bmhq_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // kind
    input  wire logic [bmhq_pkg::KIND_W-1:0]       i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // result_value, entry_count
    output logic      [bmhq_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic      [bmhq_pkg::STATUS_W-1:0]     o_m_axis_tuser
);
    import bmhq_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    logic [VALUE_W-1:0]  result_value;
    logic [ENTRY_W-1:0]  entry_count;

    bmhq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bmhq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_s_axis_tuser),
        .i_value        (i_s_axis_tdata[VALUE_W-1:0]),
        .i_position     (i_s_axis_tdata[VALUE_W +: POS_W]),
        .o_result_value (result_value),
        .o_status       (o_m_axis_tuser),
        .o_entry_count  (entry_count)
    );

    assign o_m_axis_tdata = {{OUT_PAD{1'b0}}, entry_count, result_value};

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_min_heap_queue. A scoreboard keeps its own
// min-heap in step with every accepted item and checks each result in order.
// Stimulus runs a short directed list first: empty-heap errors, extreme
// values, ties, bad positions and removal of the last entry. Random fill,
// mixed and drain phases follow. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam int STALL_PCT  = 6;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 30;
    localparam int RAND_ITEMS = 250;
    localparam int MIX_ITEMS  = 120;

    typedef struct {
        logic [VALUE_W-1:0] value;
        t_status            status;
        logic [ENTRY_W-1:0] count;
    } t_reply;

    class heap_scoreboard;
        logic signed [VALUE_W-1:0] slots [CAPACITY];
        int                        fill;
        t_reply                    expected_replies [$];
        int                        errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void swap_slots(int a, int b);
            logic signed [VALUE_W-1:0] t;
            t        = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        endfunction

        function void sift_up(int idx);
            int up;
            while (idx > 0) begin
                up = (idx - 1) / 2;
                if (!(slots[idx] < slots[up]))
                    break;
                swap_slots(idx, up);
                idx = up;
            end
        endfunction

        function void sift_down(int idx);
            int best;
            int lc;
            int rc;
            while (idx < fill) begin
                best = idx;
                lc   = 2 * idx + 1;
                rc   = 2 * idx + 2;
                if (lc < fill && slots[lc] < slots[best])
                    best = lc;
                if (rc < fill && slots[rc] < slots[best])
                    best = rc;
                if (best == idx)
                    break;
                swap_slots(idx, best);
                idx = best;
            end
        endfunction

        function void note_request(t_kind kind, logic signed [VALUE_W-1:0] value,
                                   logic [POS_W-1:0] pos);
            t_reply r;
            int     last;
            r.value  = '0;
            r.status = ST_OK;
            if (kind == KIND_INSERT) begin
                if (fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    slots[fill] = value;
                    fill++;
                    sift_up(fill - 1);
                end
            end else if (fill == 0) begin
                r.status = ST_EMPTY;
            end else if (kind == KIND_REMOVE) begin
                if (int'(pos) >= fill) begin
                    r.status = ST_BAD_POS;
                end else begin
                    last = fill - 1;
                    fill = last;
                    if (int'(pos) != last) begin
                        slots[pos] = slots[last];
                        if (pos > 0 && slots[pos] < slots[(int'(pos) - 1) / 2])
                            sift_up(int'(pos));
                        else
                            sift_down(int'(pos));
                    end
                end
            end else if (kind == KIND_EXTRACT) begin
                r.value = slots[0];
                fill--;
                if (fill > 0) begin
                    slots[0] = slots[fill];
                    sift_down(0);
                end
            end else begin
                r.value = slots[0];
            end
            r.count = fill[ENTRY_W-1:0];
            expected_replies = {expected_replies, r};
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_reply(logic [OUT_DATA_W-1:0] data, t_status status);
            t_reply e;
            if (expected_replies.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            e = expected_replies.pop_front();
            if (data[VALUE_W-1:0] !== e.value)
                report($sformatf("result_value %0d, expected %0d",
                                 $signed(data[VALUE_W-1:0]), $signed(e.value)));
            if (status !== e.status)
                report($sformatf("status %0d, expected %0d", status, e.status));
            if (data[VALUE_W +: ENTRY_W] !== e.count)
                report($sformatf("entry_count %0d, expected %0d",
                                 data[VALUE_W +: ENTRY_W], e.count));
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_DATA_W-1:0]      i_s_axis_tdata = '0;
    logic [KIND_W-1:0]         i_s_axis_tuser = '0;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]     o_m_axis_tdata;
    logic [STATUS_W-1:0]       o_m_axis_tuser;

    heap_scoreboard sb;
    int             items_sent = 0;
    bit             calm = 1'b0;
    int             idle_cycles = 0;

    binary_min_heap_queue u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_reply(o_m_axis_tdata, t_status'(o_m_axis_tuser));
        i_m_axis_tready <= calm || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL binary_min_heap_queue");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] heap_value();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return $urandom;
        else if (pick < 8)
            return VALUE_W'($signed($urandom_range(8)) - 4);
        else if (pick == 8)
            return 32'h7fff_ffff;
        else
            return 32'h8000_0000;
    endfunction

    task automatic send_item(t_kind kind, logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{IN_PAD{1'b0}}, pos, value};
        i_s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_request(kind, value, pos);
        items_sent++;
        calm = (items_sent >= 150 && items_sent < 250);
        if (!calm && $urandom_range(99) < STALL_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_mixed();
        int               pick;
        logic [POS_W-1:0] pos;
        pick = $urandom_range(99);
        pos  = POS_W'($urandom);
        if (pick < 40) begin
            send_item(KIND_INSERT, heap_value(), pos);
        end else if (pick < 65) begin
            if (sb.fill > 0 && $urandom_range(9) < 8)
                pos = POS_W'($urandom_range(sb.fill - 1));
            send_item(KIND_REMOVE, $urandom, pos);
        end else if (pick < 85) begin
            send_item(KIND_EXTRACT, $urandom, pos);
        end else begin
            send_item(KIND_PEEK, $urandom, pos);
        end
    endtask

    initial begin
        int target;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(KIND_PEEK,    32'h0, 6'd0);
        send_item(KIND_EXTRACT, 32'hffff_ffff, 6'd63);
        send_item(KIND_REMOVE,  32'h0, 6'd0);
        send_item(KIND_REMOVE,  32'h0, 6'd63);
        send_item(KIND_INSERT,  32'h7fff_ffff, 6'd0);
        send_item(KIND_INSERT,  32'h8000_0000, 6'd63);
        send_item(KIND_INSERT,  32'h0, 6'd0);
        send_item(KIND_INSERT,  32'hffff_ffff, 6'd0);
        send_item(KIND_INSERT,  32'h0, 6'd0);
        send_item(KIND_INSERT,  32'h7fff_ffff, 6'd0);
        send_item(KIND_INSERT,  32'd5, 6'd0);
        send_item(KIND_PEEK,    32'h0, 6'd0);
        send_item(KIND_REMOVE,  32'h0, 6'd63);
        send_item(KIND_REMOVE,  32'h0, 6'd7);
        send_item(KIND_REMOVE,  32'h0, 6'd6);
        send_item(KIND_REMOVE,  32'h0, 6'd0);
        send_item(KIND_REMOVE,  32'h0, 6'd2);
        send_item(KIND_EXTRACT, 32'h0, 6'd0);
        send_item(KIND_INSERT,  32'h8000_0001, 6'd0);
        repeat (5) send_item(KIND_EXTRACT, 32'h0, 6'd0);

        target = items_sent + RAND_ITEMS;
        while (items_sent < target) begin
            while (sb.fill < CAPACITY)
                send_item(KIND_INSERT, heap_value(), POS_W'($urandom));
            repeat ($urandom_range(1, 3)) send_item(KIND_INSERT, heap_value(), POS_W'($urandom));
            repeat (MIX_ITEMS) send_mixed();
            while (sb.fill > 0) begin
                if ($urandom_range(9) == 0)
                    send_item(KIND_PEEK, $urandom, POS_W'($urandom));
                else
                    send_item(KIND_EXTRACT, $urandom, POS_W'($urandom));
            end
            send_item(KIND_EXTRACT, $urandom, POS_W'($urandom));
            send_item(KIND_REMOVE, $urandom, POS_W'($urandom));
            repeat (MIX_ITEMS) send_mixed();
        end
        i_s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (sb.expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0)
            $display("PASS binary_min_heap_queue");
        else
            $display("FAIL binary_min_heap_queue");
        $finish;
    end

endmodule
